FILE: rtl/rlst_pkg.sv
// shared types and constants for the rgb led strip transmitter
// no dependencies; used by rlst_ctrl, rlst_dpath and the top level
`default_nettype none

package rlst_pkg;

    // command codes carried in the input word's tuser
    typedef enum logic [1:0] {
        CMD_SET_ONE = 2'd0,
        CMD_SET_ALL = 2'd1,
        CMD_START   = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_code_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ZERO_HIGH  = 2'd0,
        REG_ONE_HIGH   = 2'd1,
        REG_BIT_PERIOD = 2'd2,
        REG_LATCH_LOW  = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_LATCH = 2'd2
    } phase_t;

    localparam int unsigned COLOUR_W      = 24;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned IDX_W         = 3;
    localparam int unsigned BIT_W         = 3;
    localparam int unsigned SEL_W         = 2;
    localparam int unsigned TICK_W        = 16;
    localparam int unsigned CFG_W         = 16;
    localparam int unsigned IN_DATA_W     = 32;
    localparam int unsigned OUT_DATA_W    = 8;
    localparam int unsigned BYTES_PER_LED = 3;
    // led_index is three bits wide, so only the first eight leds can differ
    localparam int unsigned NUM_COLOUR_REGS = 8;

    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(BYTES_PER_LED - 1);
    localparam logic [BIT_W-1:0] BIT_LAST = '1;

    localparam logic [7:0]  RST_ZERO_HIGH  = 8'd20;
    localparam logic [7:0]  RST_ONE_HIGH   = 8'd40;
    localparam logic [7:0]  RST_BIT_PERIOD = 8'd63;
    localparam logic [15:0] RST_LATCH_LOW  = 16'd2500;

    // controller to datapath
    typedef struct packed {
        logic set_one;
        logic set_all;
        logic start;
        logic tick_send;
        logic tick_latch;
        logic send_next;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_end;
        logic latch_end;
    } dp_status_t;

    // colour words hold green, red, blue from the high byte down
    function automatic logic [BYTE_W-1:0] colour_byte(
        input logic [COLOUR_W-1:0] word,
        input logic [SEL_W-1:0]    sel
    );
        logic [BYTE_W-1:0] b;
        case (sel)
            2'd0:    b = word[23:16];
            2'd1:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rlst_ctrl.sv
// phase controller for the rgb led strip transmitter
// depends on rlst_pkg; drives rlst_dpath through ctrl_cmd_t
`default_nettype none

module rlst_ctrl #(
    parameter int unsigned NUM_LEDS = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    input  wire rlst_pkg::cmd_code_t       cmd_code,
    input  wire logic [rlst_pkg::IDX_W-1:0] led_index,
    input  wire rlst_pkg::dp_status_t      status,
    output rlst_pkg::ctrl_cmd_t            cmd,
    output logic                           busy_next,
    output logic                           frame_done,
    output logic                           rejected
);

    rlst_pkg::phase_t phase_reg;
    rlst_pkg::phase_t phase_next;
    logic busy;
    logic idx_bad;

    assign busy    = (phase_reg != rlst_pkg::PH_IDLE);
    assign idx_bad = (32'(led_index) >= NUM_LEDS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rlst_pkg::PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (item_valid)
        begin
            case (phase_reg)
                rlst_pkg::PH_IDLE:
                begin
                    if (cmd_code == rlst_pkg::CMD_START)
                        phase_next = rlst_pkg::PH_SEND;
                end
                rlst_pkg::PH_SEND:
                begin
                    if (cmd_code == rlst_pkg::CMD_TICK && status.frame_end)
                        phase_next = rlst_pkg::PH_LATCH;
                end
                rlst_pkg::PH_LATCH:
                begin
                    if (cmd_code == rlst_pkg::CMD_TICK && status.latch_end)
                        phase_next = rlst_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = rlst_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // commands and result flags
    always_comb
    begin
        cmd        = '0;
        rejected   = 1'b0;
        frame_done = 1'b0;
        if (item_valid)
        begin
            case (cmd_code)
                rlst_pkg::CMD_SET_ONE:
                begin
                    rejected    = busy || idx_bad;
                    cmd.set_one = !(busy || idx_bad);
                end
                rlst_pkg::CMD_SET_ALL:
                begin
                    rejected    = busy;
                    cmd.set_all = !busy;
                end
                rlst_pkg::CMD_START:
                begin
                    rejected  = busy;
                    cmd.start = !busy;
                end
                default:
                begin
                    cmd.tick_send  = (phase_reg == rlst_pkg::PH_SEND);
                    cmd.tick_latch = (phase_reg == rlst_pkg::PH_LATCH);
                    frame_done     = (phase_reg == rlst_pkg::PH_LATCH) && status.latch_end;
                end
            endcase
        end
        cmd.send_next = (phase_next == rlst_pkg::PH_SEND);
        busy_next     = (phase_next != rlst_pkg::PH_IDLE);
    end

    a_start_enters_send: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && phase_reg == rlst_pkg::PH_IDLE && cmd_code == rlst_pkg::CMD_START)
        |=> (phase_reg == rlst_pkg::PH_SEND))
        else $error("start from idle did not enter send");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (phase_reg == rlst_pkg::PH_IDLE))
        else $error("frame done without return to idle");

    a_no_idle_to_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rlst_pkg::PH_IDLE) |=> (phase_reg != rlst_pkg::PH_LATCH))
        else $error("latch entered straight from idle");

    a_busy_blocks_writes: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(cmd.set_one || cmd.set_all || cmd.start))
        else $error("store write or start issued while busy");

endmodule

`default_nettype wire

FILE: rtl/rlst_dpath.sv
// colour store, bit timing counters and shifter of the led strip transmitter
// depends on rlst_pkg; commanded by rlst_ctrl
`default_nettype none

module rlst_dpath #(
    parameter int unsigned NUM_LEDS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire rlst_pkg::reg_index_t          cfg_addr,
    input  wire logic [rlst_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire rlst_pkg::ctrl_cmd_t           cmd,
    input  wire logic [rlst_pkg::IDX_W-1:0]    led_index,
    input  wire logic [rlst_pkg::COLOUR_W-1:0] colour,
    output rlst_pkg::dp_status_t               status,
    output logic                               line_next
);

    localparam int unsigned LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);

    // timing registers
    logic [7:0]  zero_high_reg;
    logic [7:0]  one_high_reg;
    logic [7:0]  bit_period_reg;
    logic [15:0] latch_low_reg;

    // colour store: eight addressable words plus one word shared by the rest
    logic [rlst_pkg::COLOUR_W-1:0] colour_reg [rlst_pkg::NUM_COLOUR_REGS];
    logic [rlst_pkg::COLOUR_W-1:0] rest_colour_reg;

    logic [LED_W-1:0]                led_reg, led_next;
    logic [rlst_pkg::SEL_W-1:0]      sel_reg, sel_next;
    logic [rlst_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic [rlst_pkg::TICK_W-1:0]     tick_reg, tick_next;
    logic [rlst_pkg::BYTE_W-1:0]     shift_reg, shift_next;

    logic [rlst_pkg::TICK_W-1:0]     tick_inc;
    logic                            period_end;
    logic                            last_byte;
    logic [LED_W-1:0]                led_adv;
    logic [rlst_pkg::SEL_W-1:0]      sel_adv;
    logic [rlst_pkg::COLOUR_W-1:0]   fetch_word;
    logic [7:0]                      high_ticks;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg  <= rlst_pkg::RST_ZERO_HIGH;
            one_high_reg   <= rlst_pkg::RST_ONE_HIGH;
            bit_period_reg <= rlst_pkg::RST_BIT_PERIOD;
            latch_low_reg  <= rlst_pkg::RST_LATCH_LOW;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rlst_pkg::REG_ZERO_HIGH:  zero_high_reg  <= cfg_wdata[7:0];
                rlst_pkg::REG_ONE_HIGH:   one_high_reg   <= cfg_wdata[7:0];
                rlst_pkg::REG_BIT_PERIOD: bit_period_reg <= cfg_wdata[7:0];
                rlst_pkg::REG_LATCH_LOW:  latch_low_reg  <= cfg_wdata;
                default:                  latch_low_reg  <= latch_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rlst_pkg::NUM_COLOUR_REGS; i++)
                colour_reg[i] <= '0;
            rest_colour_reg <= '0;
        end
        else if (cmd.set_all)
        begin
            for (int i = 0; i < rlst_pkg::NUM_COLOUR_REGS; i++)
                colour_reg[i] <= colour;
            rest_colour_reg <= colour;
        end
        else if (cmd.set_one)
        begin
            colour_reg[led_index] <= colour;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg   <= '0;
            sel_reg   <= '0;
            bit_reg   <= '0;
            tick_reg  <= '0;
            shift_reg <= '0;
        end
        else
        begin
            led_reg   <= led_next;
            sel_reg   <= sel_next;
            bit_reg   <= bit_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
        end
    end

    assign tick_inc   = tick_reg + 1'b1;
    assign period_end = (tick_inc >= {8'd0, bit_period_reg});
    assign last_byte  = (led_reg == LED_LAST) && (sel_reg == rlst_pkg::SEL_LAST);

    // position of the following byte: green, red, blue, then the next led
    assign sel_adv = (sel_reg == rlst_pkg::SEL_LAST) ? '0 : sel_reg + 1'b1;
    assign led_adv = (sel_reg == rlst_pkg::SEL_LAST) ? led_reg + 1'b1 : led_reg;

    always_comb
    begin
        if (32'(led_adv) < rlst_pkg::NUM_COLOUR_REGS)
            fetch_word = colour_reg[rlst_pkg::IDX_W'(led_adv)];
        else
            fetch_word = rest_colour_reg;
    end

    always_comb
    begin
        led_next   = led_reg;
        sel_next   = sel_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        if (cmd.start)
        begin
            led_next   = '0;
            sel_next   = '0;
            bit_next   = '0;
            tick_next  = '0;
            shift_next = rlst_pkg::colour_byte(colour_reg[0], '0);
        end
        else if (cmd.tick_send)
        begin
            if (!period_end)
            begin
                tick_next = tick_inc;
            end
            else
            begin
                tick_next  = '0;
                shift_next = {shift_reg[6:0], 1'b0};
                bit_next   = bit_reg + 1'b1;
                if (bit_reg == rlst_pkg::BIT_LAST)
                begin
                    if (last_byte)
                    begin
                        led_next   = '0;
                        sel_next   = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        led_next   = led_adv;
                        sel_next   = sel_adv;
                        shift_next = rlst_pkg::colour_byte(fetch_word, sel_adv);
                    end
                end
            end
        end
        else if (cmd.tick_latch)
        begin
            tick_next = status.latch_end ? '0 : tick_inc;
        end
    end

    always_comb
    begin
        status.frame_end = period_end && (bit_reg == rlst_pkg::BIT_LAST) && last_byte;
        status.latch_end = (tick_inc >= latch_low_reg);
    end

    // line is high at the start of each bit until its high time runs out
    assign high_ticks = shift_next[7] ? one_high_reg : zero_high_reg;
    assign line_next  = cmd.send_next && (tick_next < {8'd0, high_ticks});

endmodule

`default_nettype wire

FILE: rtl/rgb_led_strip_transmitter_core.sv
// top level of the single-wire rgb led strip transmitter
// depends on rlst_pkg, rlst_ctrl and rlst_dpath
//
// usage:
//  - input words arrive on the s_axis group; tuser carries the command
//    (set one led, set all leds, start frame, tick), tdata the led index
//    and the red, green and blue intensities
//  - every accepted input word gives exactly one result word on the m_axis
//    group: line level, busy, frame done and rejected flags
//  - each tick word advances the serial waveform by one time step, so the
//    data line is rebuilt from the line_level bit of successive results
//  - latency: the result word is valid the cycle after the input word is
//    accepted; throughput is one word per clock while the receiver does not
//    stall, through the bit timing counters and the one-entry output register
//  - when the receiver stalls, the output register holds its word and
//    s_axis_tready drops until that word is taken
//  - the timing registers are written through cfg_we/cfg_addr/cfg_wdata;
//    a write takes effect on the next clock edge
//  - reset clears the colour store to black, returns to idle with the line
//    low, loads the default timing and empties the output register
`default_nettype none

module rgb_led_strip_transmitter_core #(
    parameter int unsigned NUM_LEDS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // command input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // led_index[2:0], red[10:3], green[18:11], blue[26:19], zero fill
    input  wire logic [31:0] s_axis_tdata,
    // command[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // line_level[0], busy_res[1], frame_done[2], rejected[3], zero fill
    output logic [7:0]       m_axis_tdata
);

    logic                            item_valid;
    rlst_pkg::cmd_code_t             cmd_code;
    logic [rlst_pkg::IDX_W-1:0]      led_index;
    logic [rlst_pkg::COLOUR_W-1:0]   colour;
    rlst_pkg::ctrl_cmd_t             ctrl_cmd;
    rlst_pkg::dp_status_t            dp_status;
    logic                            busy_next;
    logic                            frame_done;
    logic                            rejected;
    logic                            line_next;

    logic                            out_valid_reg, out_valid_next;
    logic [3:0]                      out_data_reg, out_data_next;

    // a new word is taken whenever the output slot is free or being emptied
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign item_valid    = s_axis_tvalid && s_axis_tready;

    assign cmd_code  = rlst_pkg::cmd_code_t'(s_axis_tuser);
    assign led_index = s_axis_tdata[2:0];
    // stored order is green, red, blue from the high byte down
    assign colour    = {s_axis_tdata[18:11], s_axis_tdata[10:3], s_axis_tdata[26:19]};

    rlst_ctrl #(
        .NUM_LEDS (NUM_LEDS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .cmd_code   (cmd_code),
        .led_index  (led_index),
        .status     (dp_status),
        .cmd        (ctrl_cmd),
        .busy_next  (busy_next),
        .frame_done (frame_done),
        .rejected   (rejected)
    );

    rlst_dpath #(
        .NUM_LEDS (NUM_LEDS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (rlst_pkg::reg_index_t'(cfg_addr)),
        .cfg_wdata (cfg_wdata),
        .cmd       (ctrl_cmd),
        .led_index (led_index),
        .colour    (colour),
        .status    (dp_status),
        .line_next (line_next)
    );

    // one-entry output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (item_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {rejected, frame_done, busy_next, line_next};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule

`default_nettype wire
